// ===== rtl/stl_pkg.sv =====
// Package for the script token lexer: token kinds, scan modes, helpers.
package stl_pkg;

  localparam int unsigned OffsetWidthDefault = 24;
  localparam int unsigned KeywordMaxLenDefault = 6;
  localparam int unsigned LineWidth = 24;
  localparam int unsigned FieldWidth = 24;
  localparam int unsigned KindWidth = 6;
  localparam int unsigned MaxResults = 4;

  typedef enum logic [3:0] {
    ModeIdle   = 4'd0,
    ModeOp     = 4'd1,
    ModeSlash  = 4'd2,
    ModeLineC  = 4'd3,
    ModeBlock  = 4'd4,
    ModeBStar  = 4'd5,
    ModeString = 4'd6,
    ModeInt    = 4'd7,
    ModeIntDot = 4'd8,
    ModeFrac   = 4'd9,
    ModeWord   = 4'd10
  } scan_mode_e;

  typedef enum logic [1:0] {
    ErrNone       = 2'd0,
    ErrUnexpected = 2'd1,
    ErrUnterm     = 2'd2
  } err_code_e;

  localparam logic [5:0] KLParen    = 6'd0;
  localparam logic [5:0] KRParen    = 6'd1;
  localparam logic [5:0] KLBrace    = 6'd2;
  localparam logic [5:0] KRBrace    = 6'd3;
  localparam logic [5:0] KComma     = 6'd4;
  localparam logic [5:0] KDot       = 6'd5;
  localparam logic [5:0] KMinus     = 6'd6;
  localparam logic [5:0] KPlus      = 6'd7;
  localparam logic [5:0] KSemicolon = 6'd8;
  localparam logic [5:0] KSlash     = 6'd9;
  localparam logic [5:0] KStar      = 6'd10;
  localparam logic [5:0] KQmark     = 6'd11;
  localparam logic [5:0] KColon     = 6'd12;
  localparam logic [5:0] KBang      = 6'd13;
  localparam logic [5:0] KEqual     = 6'd15;
  localparam logic [5:0] KGreater   = 6'd17;
  localparam logic [5:0] KLess      = 6'd19;
  localparam logic [5:0] KIdent     = 6'd21;
  localparam logic [5:0] KString    = 6'd22;
  localparam logic [5:0] KNumber    = 6'd23;
  localparam logic [5:0] KKeyword0  = 6'd24;
  localparam logic [5:0] KEndFile   = 6'd40;

  localparam int unsigned NumKeywords = 16;
  localparam int unsigned KwBytes = 6;

  typedef struct packed {
    logic [KindWidth-1:0]  kind;
    logic [FieldWidth-1:0] start;
    logic [FieldWidth-1:0] len;
    logic [1:0]            err;
    logic [7:0]            bad;
  } tok_t;

  // Keyword text, right aligned, with its length.
  function automatic logic [8*KwBytes-1:0] kw_text(input logic [3:0] k);
    logic [8*KwBytes-1:0] t;
    t = '0;
    unique case (k)
      4'd0:  t = 48'h0000_0061_6E64;
      4'd1:  t = 48'h0000_0000_6F72;
      4'd2:  t = 48'h0070_7269_6E74;
      4'd3:  t = 48'h0000_0000_6966;
      4'd4:  t = 48'h0000_656C_7365;
      4'd5:  t = 48'h0000_7472_7565;
      4'd6:  t = 48'h0066_616C_7365;
      4'd7:  t = 48'h0000_006E_696C;
      4'd8:  t = 48'h0000_0066_6F72;
      4'd9:  t = 48'h0077_6869_6C65;
      4'd10: t = 48'h0000_0066_756E;
      4'd11: t = 48'h7265_7475_726E;
      4'd12: t = 48'h0063_6C61_7373;
      4'd13: t = 48'h0073_7570_6572;
      4'd14: t = 48'h0000_7468_6973;
      4'd15: t = 48'h0000_0076_6172;
      default: t = '0;
    endcase
    return t;
  endfunction

  function automatic logic [2:0] kw_len(input logic [3:0] k);
    logic [2:0] l;
    l = 3'd0;
    unique case (k)
      4'd1, 4'd3: l = 3'd2;
      4'd0, 4'd7, 4'd8, 4'd10, 4'd15: l = 3'd3;
      4'd4, 4'd5, 4'd14: l = 3'd4;
      4'd2, 4'd6, 4'd9, 4'd12, 4'd13: l = 3'd5;
      4'd11: l = 3'd6;
      default: l = 3'd0;
    endcase
    return l;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

endpackage

// ===== rtl/script_token_lexer.sv =====
// Streaming byte scanner: one source byte in, up to four tokens out.
// The results of a byte appear in the output register in the cycle after it is accepted.
// Throughput: one byte per cycle while out_ready_i is high; the input is held while queued
// tokens of an earlier byte are still to be delivered, until the pop of the last one.
// The scan step is one combinational pass over the mode register and the byte.
// Reset clears mode, counters and the output queue; line count restarts at one.
module script_token_lexer #(
  parameter int unsigned OFFSET_WIDTH    = stl_pkg::OffsetWidthDefault,
  parameter int unsigned KEYWORD_MAX_LEN = stl_pkg::KeywordMaxLenDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  source_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [5:0]  token_kind_o,
  output logic [23:0] token_line_o,
  output logic [23:0] token_start_o,
  output logic [23:0] token_length_o,
  output logic [1:0]  error_code_o,
  output logic [7:0]  offending_byte_o,
  output logic        run_end_o
);
  import stl_pkg::*;

  localparam int unsigned WLW = $clog2(KEYWORD_MAX_LEN + 2);
  localparam int unsigned PW = 8 * KEYWORD_MAX_LEN;
  localparam logic [OFFSET_WIDTH-1:0] OffMax = '1;
  localparam logic [LineWidth-1:0] LineMax = '1;

  scan_mode_e mode_q, mode_d;
  logic [OFFSET_WIDTH-1:0] off_q, off_d, lstart_q, lstart_d, dot_q, dot_d;
  logic [LineWidth-1:0] line_q, line_d;
  logic [5:0] pend_q, pend_d;
  logic [PW-1:0] pref_q, pref_d;
  logic [WLW-1:0] wlen_q, wlen_d;

  // Result queue: up to four tokens, each with its own line value.
  tok_t toks_q [MaxResults];
  logic [LineWidth-1:0] tline_q [MaxResults];
  logic [2:0] cnt_q, idx_q;
  tok_t toks_d [MaxResults];
  logic [LineWidth-1:0] tline_d [MaxResults];
  logic [2:0] n_d;

  logic busy, accept, last_pop;

  assign busy     = (cnt_q != 3'd0);
  assign last_pop = busy && out_ready_i && (idx_q + 3'd1 == cnt_q);
  assign in_ready_o = !busy || last_pop;
  assign accept   = in_valid_i && in_ready_o;

  function automatic logic [FieldWidth-1:0] wid(input logic [OFFSET_WIDTH-1:0] v);
    logic [FieldWidth+OFFSET_WIDTH-1:0] e;
    e = {{FieldWidth{1'b0}}, v};
    return e[FieldWidth-1:0];
  endfunction

  function automatic logic [5:0] wkind_fin(input logic [PW-1:0] p, input logic [WLW-1:0] l);
    logic [8*KwBytes-1:0] cmp;
    logic [5:0] r;
    r = KIdent;
    cmp = '0;
    for (int i = 0; i < PW && i < 8 * KwBytes; i++) cmp[i] = p[i];
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      if ((l == WLW'(kw_len(4'(k)))) && (cmp == kw_text(4'(k)))) r = KKeyword0 + 6'(k);
    end
    return r;
  endfunction

  logic [5:0] wkind;
  always_comb begin
    logic [8*KwBytes-1:0] cmp;
    wkind = KIdent;
    cmp = '0;
    for (int i = 0; i < PW && i < 8 * KwBytes; i++) cmp[i] = pref_q[i];
    for (int k = NumKeywords - 1; k >= 0; k--) begin
      if ((wlen_q == WLW'(kw_len(4'(k)))) && (cmp == kw_text(4'(k)))) begin
        wkind = KKeyword0 + 6'(k);
      end
    end
  end

  always_comb begin
    logic [7:0] c;
    logic [OFFSET_WIDTH-1:0] pos, nxt, ls;
    logic [LineWidth-1:0] ln;
    logic again;
    logic [5:0] kind;
    logic single;
    logic [2:0] n_pre;
    scan_mode_e md;
    c = source_byte_i;
    pos = off_q;
    nxt = (pos < OffMax) ? pos + 1'b1 : pos;
    again = 1'b0;
    n_d = 3'd0;
    n_pre = 3'd0;
    md = mode_q;
    ls = lstart_q;
    ln = line_q;
    pend_d = pend_q;
    pref_d = pref_q;
    wlen_d = wlen_q;
    dot_d = dot_q;
    kind = '0;
    single = 1'b0;
    for (int i = 0; i < MaxResults; i++) begin
      toks_d[i] = '0;
      tline_d[i] = line_q;
    end

    unique case (mode_q)
      ModeOp: begin
        md = ModeIdle;
        if (c == 8'h3D) begin
          toks_d[0] = '{pend_q + 6'd1, wid(ls), wid(nxt - ls), ErrNone, 8'd0};
          n_d = 3'd1;
        end else begin
          toks_d[0] = '{pend_q, wid(ls), wid(pos - ls), ErrNone, 8'd0};
          n_d = 3'd1;
          again = 1'b1;
        end
      end
      ModeSlash: begin
        if (c == 8'h2F) md = ModeLineC;
        else if (c == 8'h2A) md = ModeBlock;
        else begin
          md = ModeIdle;
          toks_d[0] = '{KSlash, wid(ls), wid(pos - ls), ErrNone, 8'd0};
          n_d = 3'd1;
          again = 1'b1;
        end
      end
      ModeLineC: begin
        if (c == 8'h0A) begin
          md = ModeIdle;
          again = 1'b1;
        end
      end
      ModeBlock, ModeBStar: begin
        if (mode_q == ModeBStar && c == 8'h2F) md = ModeIdle;
        else if (c == 8'h2A) md = ModeBStar;
        else begin
          if (c == 8'h0A && ln < LineMax) ln = ln + 1'b1;
          md = ModeBlock;
        end
      end
      ModeString: begin
        if (c == 8'h22) begin
          md = ModeIdle;
          toks_d[0] = '{KString, wid(ls), wid(nxt - ls), ErrNone, 8'd0};
          n_d = 3'd1;
        end else if (c == 8'h0A && ln < LineMax) begin
          ln = ln + 1'b1;
        end
      end
      ModeInt: begin
        if (c == 8'h2E) begin
          md = ModeIntDot;
          dot_d = pos;
        end else if (!is_digit(c)) begin
          md = ModeIdle;
          toks_d[0] = '{KNumber, wid(ls), wid(pos - ls), ErrNone, 8'd0};
          n_d = 3'd1;
          again = 1'b1;
        end
      end
      ModeIntDot: begin
        if (is_digit(c)) md = ModeFrac;
        else begin
          md = ModeIdle;
          toks_d[0] = '{KNumber, wid(ls), wid(dot_q - ls), ErrNone, 8'd0};
          toks_d[1] = '{KDot, wid(dot_q), wid(pos - dot_q), ErrNone, 8'd0};
          n_d = 3'd2;
          again = 1'b1;
        end
      end
      ModeFrac: begin
        if (!is_digit(c)) begin
          md = ModeIdle;
          toks_d[0] = '{KNumber, wid(ls), wid(pos - ls), ErrNone, 8'd0};
          n_d = 3'd1;
          again = 1'b1;
        end
      end
      ModeWord: begin
        if (is_digit(c) || is_alpha(c)) begin
          if (wlen_q < WLW'(KEYWORD_MAX_LEN)) begin
            pref_d = {pref_q[PW-9:0], c};
            wlen_d = wlen_q + 1'b1;
          end else begin
            wlen_d = WLW'(KEYWORD_MAX_LEN + 1);
          end
        end else begin
          md = ModeIdle;
          toks_d[0] = '{wkind, wid(ls), wid(pos - ls), ErrNone, 8'd0};
          n_d = 3'd1;
          again = 1'b1;
        end
      end
      default: begin
        md = ModeIdle;
        again = 1'b1;
      end
    endcase

    if (again) begin
      ls = pos;
      single = 1'b1;
      unique case (c)
        8'h28: kind = KLParen;
        8'h29: kind = KRParen;
        8'h7B: kind = KLBrace;
        8'h7D: kind = KRBrace;
        8'h2C: kind = KComma;
        8'h2E: kind = KDot;
        8'h2D: kind = KMinus;
        8'h2B: kind = KPlus;
        8'h3B: kind = KSemicolon;
        8'h2A: kind = KStar;
        8'h3F: kind = KQmark;
        8'h3A: kind = KColon;
        default: single = 1'b0;
      endcase
      if (single) begin
        toks_d[n_d[1:0]] = '{kind, wid(pos), wid(nxt - pos), ErrNone, 8'd0};
        n_d = n_d + 3'd1;
      end else begin
        priority case (c)
          8'h21: begin pend_d = KBang; md = ModeOp; end
          8'h3D: begin pend_d = KEqual; md = ModeOp; end
          8'h3E: begin pend_d = KGreater; md = ModeOp; end
          8'h3C: begin pend_d = KLess; md = ModeOp; end
          8'h2F: md = ModeSlash;
          8'h20, 8'h0D, 8'h09, 8'h00: ;
          8'h0A: if (ln < LineMax) ln = ln + 1'b1;
          8'h22: md = ModeString;
          default: begin
            if (is_digit(c)) md = ModeInt;
            else if (is_alpha(c)) begin
              md = ModeWord;
              pref_d = {{(PW-8){1'b0}}, c};
              wlen_d = WLW'(1);
            end else begin
              toks_d[n_d[1:0]] = '{6'd0, wid(pos), wid(nxt - pos), ErrUnexpected, c};
              n_d = n_d + 3'd1;
            end
          end
        endcase
      end
    end

    // Tokens closed by this byte carry the line before it; end-of-source tokens the line after.
    n_pre = n_d;

    if (final_byte_i) begin
      unique case (md)
        ModeOp: begin
          toks_d[n_d[1:0]] = '{pend_d, wid(ls), wid(nxt - ls), ErrNone, 8'd0};
          n_d = n_d + 3'd1;
        end
        ModeSlash: begin
          toks_d[n_d[1:0]] = '{KSlash, wid(ls), wid(nxt - ls), ErrNone, 8'd0};
          n_d = n_d + 3'd1;
        end
        ModeString: begin
          toks_d[n_d[1:0]] = '{6'd0, wid(ls), wid(nxt - ls), ErrUnterm, 8'd0};
          n_d = n_d + 3'd1;
        end
        ModeInt, ModeFrac: begin
          toks_d[n_d[1:0]] = '{KNumber, wid(ls), wid(nxt - ls), ErrNone, 8'd0};
          n_d = n_d + 3'd1;
        end
        ModeIntDot: begin
          toks_d[n_d[1:0]] = '{KNumber, wid(ls), wid(dot_d - ls), ErrNone, 8'd0};
          n_d = n_d + 3'd1;
          toks_d[n_d[1:0]] = '{KDot, wid(dot_d), wid(nxt - dot_d), ErrNone, 8'd0};
          n_d = n_d + 3'd1;
        end
        ModeWord: begin
          // Word still open at end of source: only possible if it was not closed here.
          toks_d[n_d[1:0]] = '{wkind_fin(pref_d, wlen_d), wid(ls), wid(nxt - ls),
                               ErrNone, 8'd0};
          n_d = n_d + 3'd1;
        end
        default: ;
      endcase
      toks_d[n_d[1:0]] = '{KEndFile, wid(nxt), '0, ErrNone, 8'd0};
      n_d = n_d + 3'd1;
      mode_d = ModeIdle;
      off_d = '0;
      lstart_d = '0;
      line_d = LineWidth'(1);
      pend_d = '0;
      pref_d = '0;
      wlen_d = '0;
      dot_d = '0;
    end else begin
      mode_d = md;
      off_d = nxt;
      lstart_d = ls;
      line_d = ln;
    end

    for (int i = 0; i < MaxResults; i++) tline_d[i] = (3'(i) >= n_pre) ? ln : line_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= ModeIdle;
      off_q <= '0;
      lstart_q <= '0;
      line_q <= LineWidth'(1);
      pend_q <= '0;
      pref_q <= '0;
      wlen_q <= '0;
      dot_q <= '0;
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (accept) begin
        mode_q <= mode_d;
        off_q <= off_d;
        lstart_q <= lstart_d;
        line_q <= line_d;
        pend_q <= pend_d;
        pref_q <= pref_d;
        wlen_q <= wlen_d;
        dot_q <= dot_d;
        cnt_q <= n_d;
        idx_q <= '0;
      end else if (busy && out_ready_i) begin
        if (last_pop) begin
          cnt_q <= '0;
          idx_q <= '0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      toks_q <= toks_d;
      tline_q <= tline_d;
    end
  end

  tok_t cur;
  assign cur = toks_q[idx_q[1:0]];
  assign out_valid_o      = busy;
  assign token_kind_o     = cur.kind;
  assign token_line_o     = tline_q[idx_q[1:0]];
  assign token_start_o    = cur.start;
  assign token_length_o   = cur.len;
  assign error_code_o     = cur.err;
  assign offending_byte_o = cur.bad;
  assign run_end_o        = (idx_q + 3'd1 == cnt_q);

endmodule
